@@ src/jsv_pkg.sv @@
package jsv_pkg;

    localparam int MaxNesting = 32;
    localparam int DepthBits  = $clog2(MaxNesting + 1);
    localparam int StackBits  = (MaxNesting > 1) ? $clog2(MaxNesting) : 1;
    localparam int OffsetBits = 20;
    localparam int OutOffBits = 20;
    localparam int QueueDepth = 2;

    typedef enum logic [1:0] {
        ST_PENDING = 2'd0,
        ST_VALID   = 2'd1,
        ST_INVALID = 2'd2
    } t_status;

    typedef enum logic [3:0] {
        CL_OTHER, CL_WS, CL_LBRACE, CL_RBRACE, CL_LBRACK, CL_RBRACK, CL_QUOTE,
        CL_BSLASH, CL_MINUS, CL_PLUS, CL_ZERO, CL_DIGIT, CL_DOT, CL_EXPO,
        CL_COMMA, CL_COLON
    } t_class;

    // One classified beat handed from the front end to the parser.
    typedef struct packed {
        logic [7:0] text_byte;
        t_class     cls;
        logic       is_hex;
        logic       is_ctrl;
        logic       is_esc;
        logic       end_of_text;
    } t_item;

    function automatic t_class classify(input logic [7:0] b);
        t_class c;
        c = CL_OTHER;
        case (b)
            8'h09, 8'h0A, 8'h0D, 8'h20: c = CL_WS;
            8'h7B: c = CL_LBRACE;
            8'h7D: c = CL_RBRACE;
            8'h5B: c = CL_LBRACK;
            8'h5D: c = CL_RBRACK;
            8'h22: c = CL_QUOTE;
            8'h5C: c = CL_BSLASH;
            8'h2D: c = CL_MINUS;
            8'h2B: c = CL_PLUS;
            8'h30: c = CL_ZERO;
            8'h2E: c = CL_DOT;
            8'h65, 8'h45: c = CL_EXPO;
            8'h2C: c = CL_COMMA;
            8'h3A: c = CL_COLON;
            default: begin
                if (b >= 8'h31 && b <= 8'h39) c = CL_DIGIT;
            end
        endcase
        return c;
    endfunction

endpackage

@@ src/jsv_front.sv @@
module jsv_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_valid,
    output logic           o_ready,
    input  logic [7:0]     i_byte,
    input  logic           i_end,
    output logic           o_valid,
    input  logic           i_ready,
    output jsv_pkg::t_item o_item
);
    jsv_pkg::t_item r_q [jsv_pkg::QueueDepth];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;
    jsv_pkg::t_item w_it;
    logic w_push, w_pop;

    always_comb begin
        w_it.text_byte   = i_byte;
        w_it.cls         = jsv_pkg::classify(i_byte);
        w_it.is_hex      = (i_byte >= 8'h30 && i_byte <= 8'h39) ||
                           (i_byte >= 8'h61 && i_byte <= 8'h66) ||
                           (i_byte >= 8'h41 && i_byte <= 8'h46);
        w_it.is_ctrl     = i_byte < 8'h20;
        w_it.is_esc      = i_byte == 8'h22 || i_byte == 8'h5C || i_byte == 8'h2F ||
                           i_byte == 8'h62 || i_byte == 8'h66 || i_byte == 8'h6E ||
                           i_byte == 8'h72 || i_byte == 8'h74;
        w_it.end_of_text = i_end;
    end

    assign o_ready = r_cnt != 2'd2;
    assign o_valid = r_cnt != 2'd0;
    assign o_item  = r_q[r_rp];
    assign w_push  = i_valid && o_ready;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (w_push) r_q[r_wp] <= w_it;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
    end
endmodule

@@ src/jsv_parser.sv @@
module jsv_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [5:0]                    i_limit,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  jsv_pkg::t_item                i_item,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [1:0]                    o_status,
    output logic [jsv_pkg::OutOffBits-1:0] o_offset,
    output logic [5:0]                    o_depth
);
    typedef enum logic [4:0] {
        M_VALUE, M_ARR_FIRST, M_OBJ_FIRST, M_KEY, M_COLON, M_AFTER, M_STR,
        M_STR_ESC, M_STR_HEX, M_NUM_SIGN, M_NUM_ZERO, M_NUM_INT, M_NUM_DOT,
        M_NUM_FRAC, M_NUM_EXP, M_NUM_EXPSIGN, M_NUM_EXPDIG, M_LIT_TRUE,
        M_LIT_FALSE, M_LIT_NULL
    } t_mode;

    localparam int DB = jsv_pkg::DepthBits;
    localparam int OB = jsv_pkg::OffsetBits;
    localparam logic [OB-1:0] OffCap = '1;

    t_mode r_mode, n_mode;
    logic  r_stack [jsv_pkg::MaxNesting];
    logic [DB-1:0] r_depth, n_depth;
    logic [2:0] r_sub, n_sub;
    logic [OB-1:0] r_pos, r_epos;
    logic r_err, n_fail;
    logic r_ovalid;
    logic [1:0] r_status;
    logic [jsv_pkg::OutOffBits-1:0] r_offset;
    logic [5:0] r_odepth;
    logic w_take, w_push, w_pushv, w_top;
    logic [DB-1:0] w_lim;
    logic [7:0] b;
    jsv_pkg::t_class c;

    function automatic logic [jsv_pkg::StackBits-1:0] StackIdx(input logic [DB-1:0] d);
        return d[jsv_pkg::StackBits-1:0];
    endfunction

    assign o_ready  = !r_ovalid || i_ready;
    assign w_take   = i_valid && o_ready;
    assign o_valid  = r_ovalid;
    assign o_status = r_status;
    assign o_offset = r_offset;
    assign o_depth  = r_odepth;
    assign b = i_item.text_byte;
    assign c = i_item.cls;
    assign w_lim = ({2'b0, i_limit} > 8'(jsv_pkg::MaxNesting)) ?
                   DB'(jsv_pkg::MaxNesting) : DB'(i_limit);
    assign w_top = (r_depth != '0) ? r_stack[StackIdx(r_depth - 1'b1)] : 1'b0;

    // Next parser state for one byte; opening brackets also push the stack.
    always_comb begin
        logic [7:0] want;
        logic [2:0] len;
        n_mode = r_mode; n_depth = r_depth; n_sub = r_sub; n_fail = 1'b0;
        w_push = 1'b0; w_pushv = 1'b0; want = 8'h00; len = 3'd4;
        case (r_mode)
            M_VALUE, M_ARR_FIRST: begin
                if (c == jsv_pkg::CL_WS) begin
                end else if (r_mode == M_ARR_FIRST && c == jsv_pkg::CL_RBRACK) begin
                    n_depth = r_depth - 1'b1; n_mode = M_AFTER;
                end else if (c == jsv_pkg::CL_LBRACE || c == jsv_pkg::CL_LBRACK) begin
                    if (r_depth >= w_lim) n_fail = 1'b1;
                    else begin
                        w_push = 1'b1; w_pushv = c == jsv_pkg::CL_LBRACE;
                        n_depth = r_depth + 1'b1;
                        n_mode = w_pushv ? M_OBJ_FIRST : M_ARR_FIRST;
                    end
                end else if (c == jsv_pkg::CL_QUOTE) begin
                    n_mode = M_STR; n_sub = 3'd0;
                end else if (c == jsv_pkg::CL_MINUS) n_mode = M_NUM_SIGN;
                else if (c == jsv_pkg::CL_ZERO) n_mode = M_NUM_ZERO;
                else if (c == jsv_pkg::CL_DIGIT) n_mode = M_NUM_INT;
                else if (b == 8'h74) begin n_mode = M_LIT_TRUE; n_sub = 3'd1; end
                else if (b == 8'h66) begin n_mode = M_LIT_FALSE; n_sub = 3'd1; end
                else if (b == 8'h6E) begin n_mode = M_LIT_NULL; n_sub = 3'd1; end
                else n_fail = 1'b1;
            end
            M_OBJ_FIRST, M_KEY: begin
                if (c == jsv_pkg::CL_WS) begin
                end else if (r_mode == M_OBJ_FIRST && c == jsv_pkg::CL_RBRACE) begin
                    n_depth = r_depth - 1'b1; n_mode = M_AFTER;
                end else if (c == jsv_pkg::CL_QUOTE) begin
                    n_mode = M_STR; n_sub = 3'd4;
                end else n_fail = 1'b1;
            end
            M_COLON: begin
                if (c == jsv_pkg::CL_COLON) n_mode = M_VALUE;
                else if (c != jsv_pkg::CL_WS) n_fail = 1'b1;
            end
            M_STR: begin
                if (c == jsv_pkg::CL_QUOTE) begin
                    n_mode = r_sub[2] ? M_COLON : M_AFTER; n_sub = 3'd0;
                end else if (c == jsv_pkg::CL_BSLASH) n_mode = M_STR_ESC;
                else if (i_item.is_ctrl) n_fail = 1'b1;
            end
            M_STR_ESC: begin
                if (i_item.is_esc) n_mode = M_STR;
                else if (b == 8'h75) begin
                    n_mode = M_STR_HEX; n_sub = {r_sub[2], 2'b00};
                end else n_fail = 1'b1;
            end
            M_STR_HEX: begin
                if (!i_item.is_hex) n_fail = 1'b1;
                else if (r_sub[1:0] == 2'b11) begin
                    n_sub = {r_sub[2], 2'b00}; n_mode = M_STR;
                end else n_sub = r_sub + 3'd1;
            end
            M_LIT_TRUE, M_LIT_FALSE, M_LIT_NULL: begin
                case (r_mode)
                    M_LIT_TRUE: begin
                        len = 3'd4;
                        case (r_sub)
                            3'd1: want = 8'h72; 3'd2: want = 8'h75; 3'd3: want = 8'h65;
                            default: want = 8'h74;
                        endcase
                    end
                    M_LIT_FALSE: begin
                        len = 3'd5;
                        case (r_sub)
                            3'd1: want = 8'h61; 3'd2: want = 8'h6C; 3'd3: want = 8'h73;
                            3'd4: want = 8'h65; default: want = 8'h66;
                        endcase
                    end
                    default: begin
                        len = 3'd4;
                        case (r_sub)
                            3'd1: want = 8'h75; 3'd2, 3'd3: want = 8'h6C;
                            default: want = 8'h6E;
                        endcase
                    end
                endcase
                if (r_sub >= len || b != want) n_fail = 1'b1;
                else if (r_sub + 3'd1 >= len) begin n_sub = 3'd0; n_mode = M_AFTER; end
                else n_sub = r_sub + 3'd1;
            end
            M_NUM_SIGN: begin
                if (c == jsv_pkg::CL_ZERO) n_mode = M_NUM_ZERO;
                else if (c == jsv_pkg::CL_DIGIT) n_mode = M_NUM_INT;
                else n_fail = 1'b1;
            end
            M_NUM_DOT: begin
                if (c == jsv_pkg::CL_ZERO || c == jsv_pkg::CL_DIGIT) n_mode = M_NUM_FRAC;
                else n_fail = 1'b1;
            end
            M_NUM_EXP: begin
                if (c == jsv_pkg::CL_PLUS || c == jsv_pkg::CL_MINUS) n_mode = M_NUM_EXPSIGN;
                else if (c == jsv_pkg::CL_ZERO || c == jsv_pkg::CL_DIGIT)
                    n_mode = M_NUM_EXPDIG;
                else n_fail = 1'b1;
            end
            M_NUM_EXPSIGN: begin
                if (c == jsv_pkg::CL_ZERO || c == jsv_pkg::CL_DIGIT) n_mode = M_NUM_EXPDIG;
                else n_fail = 1'b1;
            end
            default: ;
        endcase
        // Modes where a value has ended, or a number may end on this byte.
        if (r_mode == M_AFTER ||
            ((r_mode == M_NUM_ZERO || r_mode == M_NUM_INT || r_mode == M_NUM_FRAC ||
              r_mode == M_NUM_EXPDIG) &&
             !((r_mode != M_NUM_ZERO) &&
               (c == jsv_pkg::CL_ZERO || c == jsv_pkg::CL_DIGIT)) &&
             !(r_mode != M_NUM_EXPDIG && c == jsv_pkg::CL_EXPO) &&
             !((r_mode == M_NUM_ZERO || r_mode == M_NUM_INT) && c == jsv_pkg::CL_DOT))) begin
            n_mode = M_AFTER;
            if (c == jsv_pkg::CL_WS) begin
            end else if (r_depth == '0) n_fail = 1'b1;
            else if (c == jsv_pkg::CL_COMMA) n_mode = w_top ? M_KEY : M_VALUE;
            else if ((w_top && c == jsv_pkg::CL_RBRACE) ||
                     (!w_top && c == jsv_pkg::CL_RBRACK)) n_depth = r_depth - 1'b1;
            else n_fail = 1'b1;
        end else if (r_mode == M_NUM_ZERO || r_mode == M_NUM_INT) begin
            if (c == jsv_pkg::CL_DOT) n_mode = M_NUM_DOT;
            else if (c == jsv_pkg::CL_EXPO) n_mode = M_NUM_EXP;
        end else if (r_mode == M_NUM_FRAC && c == jsv_pkg::CL_EXPO) n_mode = M_NUM_EXP;
        if (n_fail) begin
            n_mode = r_mode; n_depth = r_depth; n_sub = r_sub; w_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        logic done;
        done = (r_mode == M_AFTER || r_mode == M_NUM_ZERO || r_mode == M_NUM_INT ||
                r_mode == M_NUM_FRAC || r_mode == M_NUM_EXPDIG) && r_depth == '0;
        if (w_take && !i_item.end_of_text && !r_err && w_push)
            r_stack[StackIdx(r_depth)] <= w_pushv;
        if (w_take) begin
            // A byte beat reports the depth after that byte; the end beat the depth before.
            r_odepth <= 6'((i_item.end_of_text || r_err) ? r_depth : n_depth);
            if (i_item.end_of_text) begin
                r_status <= (!r_err && done) ? jsv_pkg::ST_VALID : jsv_pkg::ST_INVALID;
                r_offset <= r_err ? jsv_pkg::OutOffBits'(r_epos) :
                            done ? '0 : jsv_pkg::OutOffBits'(r_pos);
            end else begin
                r_status <= (r_err || n_fail) ? jsv_pkg::ST_INVALID : jsv_pkg::ST_PENDING;
                r_offset <= r_err ? jsv_pkg::OutOffBits'(r_epos) :
                            n_fail ? jsv_pkg::OutOffBits'(r_pos) : '0;
            end
        end
        if (!i_rst_n) begin
            r_mode <= M_VALUE; r_depth <= '0; r_sub <= '0; r_pos <= '0;
            r_err <= 1'b0; r_epos <= '0; r_ovalid <= 1'b0;
        end else begin
            if (w_take) r_ovalid <= 1'b1;
            else if (i_ready) r_ovalid <= 1'b0;
            if (w_take) begin
                if (i_item.end_of_text) begin
                    r_mode <= M_VALUE; r_depth <= '0; r_sub <= '0; r_pos <= '0;
                    r_err <= 1'b0; r_epos <= '0;
                end else begin
                    if (r_pos != OffCap) r_pos <= r_pos + 1'b1;
                    if (!r_err) begin
                        r_mode <= n_mode; r_depth <= n_depth; r_sub <= n_sub;
                        if (n_fail) begin r_err <= 1'b1; r_epos <= r_pos; end
                    end
                end
            end
        end
    end
endmodule

@@ src/json_syntax_validator.sv @@
// JSON syntax checker, one text byte per beat.
// Input stream: s_axis_tdata carries the text byte, s_axis_tlast marks the end
// of a document (the byte on that beat is ignored). Every input beat yields
// exactly one output beat on m_axis with the status (pending, valid, invalid),
// the offset of the first error and the current nesting depth.
// A front stage classifies each byte and writes it into a two-entry queue; the
// parser drains that queue into a registered output stage, one beat per cycle
// while the receiver is not stalling. An accepted beat is registered first in
// the queue and then in the output stage, and the sustained rate is one beat
// per cycle as long as the receiver accepts every output beat.
// The end beat returns the parser to its start state for the next document;
// the nesting limit register is kept. Reset (synchronous, active low) empties
// the queue and output stage, clears the parser and sets the limit to 32.
// When the receiver stalls, the output stage holds its beat, the queue fills,
// and s_axis_tready falls after at most two further beats.
// The limit may only be written while no beat is in flight.
module json_syntax_validator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [5:0]  i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // text_byte
    input  logic        s_axis_tlast,   // end_of_text
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // status[1:0], error_offset[21:2], depth[27:22]
);
    logic [5:0]     r_limit;
    logic           w_qvalid, w_qready;
    jsv_pkg::t_item w_item;
    logic [1:0]     w_status;
    logic [19:0]    w_offset;
    logic [5:0]     w_depth;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_limit <= 6'd32;
        else if (i_cfg_we) r_limit <= i_cfg_wdata;
    end

    jsv_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready),
        .i_byte(s_axis_tdata), .i_end(s_axis_tlast),
        .o_valid(w_qvalid), .i_ready(w_qready), .o_item(w_item)
    );

    jsv_parser u_parser (
        .i_clk, .i_rst_n, .i_limit(r_limit),
        .i_valid(w_qvalid), .o_ready(w_qready), .i_item(w_item),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_status(w_status), .o_offset(w_offset), .o_depth(w_depth)
    );

    assign m_axis_tdata = {4'd0, w_depth, w_offset, w_status};

    // A valid verdict never carries an error offset.
    a_valid_no_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tdata[1:0] == jsv_pkg::ST_VALID |->
        m_axis_tdata[21:2] == 20'd0) else $error("valid status with offset");
    // Status code 3 is never produced.
    a_no_code3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[1:0] != 2'd3) else $error("bad status");
    // Reported depth never exceeds the hard nesting bound.
    a_depth_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[27:22] <= 6'd32) else $error("depth overflow");
endmodule
